>>> hw/rtl/rrch_pkg.sv
// Types, codes and constants of the rotated rectangle / circle hit block.
// No dependencies; every other file but rrch_if takes names from here by scope.
`timescale 1ns / 1ps
`default_nettype none
package rrch_pkg;

    localparam int PADDR_W    = 4;
    localparam int ATAN_IDX_W = 5;

    // register indexes (paddr[3:2])
    localparam logic [1:0] REG_CIRCLE_X = 2'd0;
    localparam logic [1:0] REG_CIRCLE_Y = 2'd1;
    localparam logic [1:0] REG_CIRCLE_R = 2'd2;

    // angles in Q2.30, kept in 34 bits
    localparam logic signed [33:0] ANG_HALF_PI = 34'sd1686629713;
    localparam logic signed [33:0] ANG_PI      = 34'sd3373259426;
    localparam logic signed [33:0] INV_GAIN    = 34'sd652032874;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CORDIC,
        S_ROT,
        S_EDGE,
        S_CORN,
        S_DONE
    } t_state;

    typedef enum logic [2:0] {
        MUL_DXC,
        MUL_DYS,
        MUL_DXS,
        MUL_DYC,
        MUL_EXX,
        MUL_EYY,
        MUL_RR
    } t_mul_op;

    typedef enum logic [2:0] {
        ACC_NONE,
        ACC_RX_LD,
        ACC_RX_SUB,
        ACC_RY_LD,
        ACC_RY_ADD,
        ACC_SQ_LD,
        ACC_SQ_ADD,
        ACC_RR_LD
    } t_acc_op;

    typedef struct packed {
        logic                  load;
        logic                  cordic_step;
        logic [ATAN_IDX_W-1:0] step_idx;
        t_mul_op               mul_op;
        t_acc_op               acc_op;
        logic                  edge_ld;
        logic                  done;
    } t_cmd;

    typedef struct packed {
        logic in_valid;
        logic group_end;
        logic out_blocked;
    } t_sts;

    // truncated arctangent table, Q2.30
    function automatic logic [31:0] atan_q30(input logic [ATAN_IDX_W-1:0] idx);
        logic [31:0] v;
        unique case (idx)
            5'd0:    v = 32'h3243F6A8;
            5'd1:    v = 32'h1DAC6705;
            5'd2:    v = 32'h0FADBAFC;
            5'd3:    v = 32'h07F56EA6;
            5'd4:    v = 32'h03FEAB76;
            5'd5:    v = 32'h01FFD55B;
            5'd6:    v = 32'h00FFFAAA;
            5'd7:    v = 32'h007FFF55;
            5'd8:    v = 32'h003FFFEA;
            5'd9:    v = 32'h001FFFFD;
            5'd10:   v = 32'h000FFFFF;
            5'd11:   v = 32'h0007FFFF;
            5'd12:   v = 32'h0003FFFF;
            5'd13:   v = 32'h0001FFFF;
            5'd14:   v = 32'h0000FFFF;
            5'd15:   v = 32'h00007FFF;
            5'd16:   v = 32'h00003FFF;
            5'd17:   v = 32'h00001FFF;
            5'd18:   v = 32'h00000FFF;
            5'd19:   v = 32'h000007FF;
            5'd20:   v = 32'h000003FF;
            5'd21:   v = 32'h000001FF;
            5'd22:   v = 32'h000000FF;
            5'd23:   v = 32'h0000007F;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

>>> hw/rtl/rrch_if.sv
// Valid/ready channel interfaces for rectangle words and result words.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
interface rrch_rect_if;
    logic        valid;
    logic        ready;
    logic [31:0] rect_id;
    logic [31:0] rect_cx;
    logic [31:0] rect_cy;
    logic [30:0] half_w;
    logic [30:0] half_h;
    logic [15:0] rot_angle;
    logic        group_end;

    modport source (output valid, rect_id, rect_cx, rect_cy, half_w, half_h,
                    rot_angle, group_end, input ready);
    modport sink   (input valid, rect_id, rect_cx, rect_cy, half_w, half_h,
                    rot_angle, group_end, output ready);
endinterface

interface rrch_hit_if;
    logic        valid;
    logic        ready;
    logic [31:0] hit_id;

    modport source (output valid, hit_id, input ready);
    modport sink   (input valid, hit_id, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/rrch_regs.sv
// APB-style configuration registers: circle centre and radius.
// Depends on rrch_pkg for register indexes and address width.
`timescale 1ns / 1ps
`default_nettype none
module rrch_regs (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [rrch_pkg::PADDR_W-1:0] paddr,
    input  wire logic [31:0]                pwdata,
    output logic      [31:0]                prdata,
    output logic                            pready,
    output logic      [31:0]                o_circle_x,
    output logic      [31:0]                o_circle_y,
    output logic      [30:0]                o_circle_r
);
    logic [31:0] r_cx;
    logic [31:0] r_cy;
    logic [30:0] r_cr;
    logic        wr;
    logic [1:0]  idx;

    assign idx    = paddr[3:2];
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx <= '0;
            r_cy <= '0;
            r_cr <= '0;
        end else if (wr) begin
            if (idx == rrch_pkg::REG_CIRCLE_X) r_cx <= pwdata;
            if (idx == rrch_pkg::REG_CIRCLE_Y) r_cy <= pwdata;
            if (idx == rrch_pkg::REG_CIRCLE_R) r_cr <= pwdata[30:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (idx == rrch_pkg::REG_CIRCLE_X) prdata = r_cx;
        if (idx == rrch_pkg::REG_CIRCLE_Y) prdata = r_cy;
        if (idx == rrch_pkg::REG_CIRCLE_R) prdata = {1'b0, r_cr};
    end

    assign o_circle_x = r_cx;
    assign o_circle_y = r_cy;
    assign o_circle_r = r_cr;
endmodule
`default_nettype wire

>>> hw/rtl/rrch_ctrl.sv
// Sequencer: accept, CORDIC steps, shared multiplier schedule, decision.
// Depends on rrch_pkg for state, command and status types.
`timescale 1ns / 1ps
`default_nettype none
module rrch_ctrl #(
    parameter int CORDIC_STEPS = 16
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire rrch_pkg::t_sts i_sts,
    output rrch_pkg::t_cmd     o_cmd,
    output logic               o_in_ready
);
    localparam int STEP_W = $clog2(CORDIC_STEPS);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CORDIC_STEPS - 1);

    rrch_pkg::t_state r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;
    logic [2:0]        r_sub, n_sub;
    logic              fire;

    assign o_in_ready = (r_state == rrch_pkg::S_IDLE);
    assign fire       = o_in_ready && i_sts.in_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rrch_pkg::S_IDLE;
            r_step  <= '0;
            r_sub   <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_sub   <= n_sub;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_sub   = r_sub;
        unique case (r_state)
            rrch_pkg::S_IDLE: begin
                n_step = '0;
                n_sub  = '0;
                if (fire) n_state = rrch_pkg::S_CORDIC;
            end
            rrch_pkg::S_CORDIC: begin
                n_step = r_step + 1'b1;
                if (r_step == LAST_STEP) n_state = rrch_pkg::S_ROT;
            end
            rrch_pkg::S_ROT: begin
                n_sub = r_sub + 1'b1;
                if (r_sub == 3'd4) begin
                    n_sub   = '0;
                    n_state = rrch_pkg::S_EDGE;
                end
            end
            rrch_pkg::S_EDGE: n_state = rrch_pkg::S_CORN;
            rrch_pkg::S_CORN: begin
                n_sub = r_sub + 1'b1;
                if (r_sub == 3'd3) begin
                    n_sub   = '0;
                    n_state = rrch_pkg::S_DONE;
                end
            end
            rrch_pkg::S_DONE: begin
                if (!(i_sts.group_end && i_sts.out_blocked)) n_state = rrch_pkg::S_IDLE;
            end
            default: n_state = rrch_pkg::S_IDLE;
        endcase
    end

    // commands
    always_comb begin
        o_cmd             = '0;
        o_cmd.mul_op      = rrch_pkg::MUL_DXC;
        o_cmd.acc_op      = rrch_pkg::ACC_NONE;
        o_cmd.load        = fire;
        o_cmd.step_idx    = rrch_pkg::ATAN_IDX_W'(r_step);
        unique case (r_state)
            rrch_pkg::S_CORDIC: o_cmd.cordic_step = 1'b1;
            rrch_pkg::S_ROT: begin
                unique case (r_sub)
                    3'd0: o_cmd.mul_op = rrch_pkg::MUL_DXC;
                    3'd1: begin
                        o_cmd.mul_op = rrch_pkg::MUL_DYS;
                        o_cmd.acc_op = rrch_pkg::ACC_RX_LD;
                    end
                    3'd2: begin
                        o_cmd.mul_op = rrch_pkg::MUL_DXS;
                        o_cmd.acc_op = rrch_pkg::ACC_RX_SUB;
                    end
                    3'd3: begin
                        o_cmd.mul_op = rrch_pkg::MUL_DYC;
                        o_cmd.acc_op = rrch_pkg::ACC_RY_LD;
                    end
                    default: o_cmd.acc_op = rrch_pkg::ACC_RY_ADD;
                endcase
            end
            rrch_pkg::S_EDGE: o_cmd.edge_ld = 1'b1;
            rrch_pkg::S_CORN: begin
                unique case (r_sub)
                    3'd0: o_cmd.mul_op = rrch_pkg::MUL_EXX;
                    3'd1: begin
                        o_cmd.mul_op = rrch_pkg::MUL_EYY;
                        o_cmd.acc_op = rrch_pkg::ACC_SQ_LD;
                    end
                    3'd2: begin
                        o_cmd.mul_op = rrch_pkg::MUL_RR;
                        o_cmd.acc_op = rrch_pkg::ACC_SQ_ADD;
                    end
                    default: o_cmd.acc_op = rrch_pkg::ACC_RR_LD;
                endcase
            end
            rrch_pkg::S_DONE: o_cmd.done = !(i_sts.group_end && i_sts.out_blocked);
            default: ;
        endcase
    end

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> (r_state == rrch_pkg::S_CORDIC) && (r_step == '0))
        else $error("accepted word did not start CORDIC");
    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rrch_pkg::S_CORDIC) |-> (r_step <= LAST_STEP))
        else $error("CORDIC step past end");
    a_done_retires: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.done |=> (r_state == rrch_pkg::S_IDLE))
        else $error("finished word did not return to idle");
endmodule
`default_nettype wire

>>> hw/rtl/rrch_dp.sv
// Datapath: angle fold, CORDIC registers, shared multiplier, edge test,
// running maximum and result register. Depends on rrch_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rrch_dp (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire rrch_pkg::t_cmd i_cmd,
    output rrch_pkg::t_sts      o_sts,
    input  wire logic [31:0]    i_circle_x,
    input  wire logic [31:0]    i_circle_y,
    input  wire logic [30:0]    i_circle_r,
    input  wire logic           i_in_valid,
    input  wire logic [31:0]    i_rect_id,
    input  wire logic [31:0]    i_rect_cx,
    input  wire logic [31:0]    i_rect_cy,
    input  wire logic [30:0]    i_half_w,
    input  wire logic [30:0]    i_half_h,
    input  wire logic [15:0]    i_rot_angle,
    input  wire logic           i_group_end,
    input  wire logic           i_out_ready,
    output logic                o_out_valid,
    output logic [31:0]         o_hit_id
);
    logic [31:0]        r_id;
    logic signed [32:0] r_dx, r_dy;
    logic [30:0]        r_hw, r_hh;
    logic               r_ge, r_neg;
    logic signed [33:0] r_x, r_y, r_z;
    logic signed [65:0] r_prod;
    logic signed [59:0] r_rx, r_ry;
    logic signed [36:0] r_ex, r_ey;
    logic [63:0]        r_sq, r_rr;
    logic [31:0]        r_best;
    logic               r_out_valid;
    logic [31:0]        r_out;

    // angle fold to within +-pi/2
    logic signed [33:0] z_in, z_fold;
    logic               neg_in;
    always_comb begin
        z_in   = {i_rot_angle[15], i_rot_angle, 17'b0};
        z_fold = z_in;
        neg_in = 1'b0;
        if (z_in > rrch_pkg::ANG_HALF_PI) begin
            z_fold = z_in - rrch_pkg::ANG_PI;
            neg_in = 1'b1;
        end else if (z_in < -rrch_pkg::ANG_HALF_PI) begin
            z_fold = z_in + rrch_pkg::ANG_PI;
            neg_in = 1'b1;
        end
    end

    // one CORDIC rotation
    logic signed [33:0] xs, ys, atan_v;
    assign xs     = r_x >>> i_cmd.step_idx;
    assign ys     = r_y >>> i_cmd.step_idx;
    assign atan_v = {2'b00, rrch_pkg::atan_q30(i_cmd.step_idx)};

    // cos / sin in Q1.24 after the fold sign
    logic signed [33:0] xn, yn, c_q24, s_q24;
    assign xn    = r_neg ? -r_x : r_x;
    assign yn    = r_neg ? -r_y : r_y;
    assign c_q24 = xn >>> 6;
    assign s_q24 = yn >>> 6;

    // shared multiplier operands
    logic signed [32:0] ma, mb;
    always_comb begin
        ma = r_dx;
        mb = c_q24[32:0];
        unique case (i_cmd.mul_op)
            rrch_pkg::MUL_DXC: begin ma = r_dx; mb = c_q24[32:0]; end
            rrch_pkg::MUL_DYS: begin ma = r_dy; mb = s_q24[32:0]; end
            rrch_pkg::MUL_DXS: begin ma = r_dx; mb = s_q24[32:0]; end
            rrch_pkg::MUL_DYC: begin ma = r_dy; mb = c_q24[32:0]; end
            rrch_pkg::MUL_EXX: begin ma = r_ex[32:0]; mb = r_ex[32:0]; end
            rrch_pkg::MUL_EYY: begin ma = r_ey[32:0]; mb = r_ey[32:0]; end
            rrch_pkg::MUL_RR:  begin ma = {2'b00, i_circle_r}; mb = {2'b00, i_circle_r}; end
            default: ;
        endcase
    end

    // edge distances past the half extents
    logic [59:0] mag_rx, mag_ry;
    assign mag_rx = r_rx[59] ? 60'(-r_rx) : 60'(r_rx);
    assign mag_ry = r_ry[59] ? 60'(-r_ry) : 60'(r_ry);

    // hit decision
    logic signed [36:0] rad;
    logic               hit;
    logic [31:0]        n_best;
    assign rad    = {6'b0, i_circle_r};
    assign hit    = (r_ex <= rad) && (r_ey <= rad) &&
                    ((r_ex <= 0) || (r_ey <= 0) || (r_sq <= r_rr));
    assign n_best = (hit && (r_id > r_best)) ? r_id : r_best;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_id  <= i_rect_id;
            r_dx  <= $signed({i_circle_x[31], i_circle_x}) - $signed({i_rect_cx[31], i_rect_cx});
            r_dy  <= $signed({i_circle_y[31], i_circle_y}) - $signed({i_rect_cy[31], i_rect_cy});
            r_hw  <= i_half_w;
            r_hh  <= i_half_h;
            r_ge  <= i_group_end;
            r_neg <= neg_in;
            r_z   <= z_fold;
            r_x   <= rrch_pkg::INV_GAIN;
            r_y   <= '0;
        end else if (i_cmd.cordic_step) begin
            if (r_z >= 0) begin
                r_x <= r_x - ys;
                r_y <= r_y + xs;
                r_z <= r_z - atan_v;
            end else begin
                r_x <= r_x + ys;
                r_y <= r_y - xs;
                r_z <= r_z + atan_v;
            end
        end
        r_prod <= ma * mb;
        unique case (i_cmd.acc_op)
            rrch_pkg::ACC_RX_LD:  r_rx <= r_prod[59:0];
            rrch_pkg::ACC_RX_SUB: r_rx <= r_rx - r_prod[59:0];
            rrch_pkg::ACC_RY_LD:  r_ry <= r_prod[59:0];
            rrch_pkg::ACC_RY_ADD: r_ry <= r_ry + r_prod[59:0];
            rrch_pkg::ACC_SQ_LD:  r_sq <= r_prod[63:0];
            rrch_pkg::ACC_SQ_ADD: r_sq <= r_sq + r_prod[63:0];
            rrch_pkg::ACC_RR_LD:  r_rr <= r_prod[63:0];
            default: ;
        endcase
        if (i_cmd.edge_ld) begin
            r_ex <= $signed({1'b0, mag_rx[59:24]}) - $signed({6'b0, r_hw});
            r_ey <= $signed({1'b0, mag_ry[59:24]}) - $signed({6'b0, r_hh});
        end
        if (i_cmd.done && r_ge) r_out <= n_best;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.done) r_best <= r_ge ? 32'd0 : n_best;
            if (i_cmd.done && r_ge) r_out_valid <= 1'b1;
            else if (i_out_ready)   r_out_valid <= 1'b0;
        end
    end

    assign o_sts.in_valid    = i_in_valid;
    assign o_sts.group_end   = r_ge;
    assign o_sts.out_blocked = r_out_valid && !i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_hit_id          = r_out;

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_out_valid && $past(i_rst_n)) ##1 r_out_valid |-> $past(i_cmd.done && r_ge))
        else $error("result word without a group end");
endmodule
`default_nettype wire

>>> hw/rtl/rotated_rect_circle_hit.sv
// Top level of the rotated rectangle / circle hit block.
// Depends on rrch_pkg, rrch_if, rrch_regs, rrch_ctrl and rrch_dp.
`timescale 1ns / 1ps
`default_nettype none
// The circle (centre, radius) is set through the APB-style port: circle_x at
// 0x0, circle_y at 0x4, circle_radius at 0x8, all Q16.16. Each rectangle
// word on i_rect is tested against that circle; the largest nonzero id that
// hits is kept, and the word with group_end set sends it (0 if none hit) as a
// result word on o_hit and clears it. One word is worked at a time: the
// accept, the CORDIC iterations, the four rotation products through the one
// shared multiplier, the edge distances, the three corner products and the
// decision all pass before the next ready. A group end whose result register
// is still full holds in the decide state until the earlier result word is
// taken.
module rotated_rect_circle_hit #(
    parameter int CORDIC_STEPS = 16
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [rrch_pkg::PADDR_W-1:0] paddr,
    input  wire logic [31:0]                  pwdata,
    output logic      [31:0]                  prdata,
    output logic                              pready,
    rrch_rect_if.sink                         i_rect,
    rrch_hit_if.source                        o_hit
);
    logic [31:0]    circle_x, circle_y;
    logic [30:0]    circle_r;
    rrch_pkg::t_cmd cmd;
    rrch_pkg::t_sts sts;
    logic           in_ready;

    rrch_regs u_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .o_circle_x (circle_x),
        .o_circle_y (circle_y),
        .o_circle_r (circle_r)
    );

    rrch_ctrl #(.CORDIC_STEPS(CORDIC_STEPS)) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_in_ready (in_ready)
    );

    assign i_rect.ready = in_ready;

    rrch_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_circle_x  (circle_x),
        .i_circle_y  (circle_y),
        .i_circle_r  (circle_r),
        .i_in_valid  (i_rect.valid),
        .i_rect_id   (i_rect.rect_id),
        .i_rect_cx   (i_rect.rect_cx),
        .i_rect_cy   (i_rect.rect_cy),
        .i_half_w    (i_rect.half_w),
        .i_half_h    (i_rect.half_h),
        .i_rot_angle (i_rect.rot_angle),
        .i_group_end (i_rect.group_end),
        .i_out_ready (o_hit.ready),
        .o_out_valid (o_hit.valid),
        .o_hit_id    (o_hit.hit_id)
    );
endmodule
`default_nettype wire

>>> tb/sv/rotated_rect_circle_hit_test.sv
// Testbench for rotated_rect_circle_hit: drives rectangle words and APB writes,
// predicts group hit ids with an in-bench CORDIC/hit model and checks o_hit.
// Depends on rrch_pkg, rrch_if and the RTL of the block.
`timescale 1ns / 1ps
module rotated_rect_circle_hit_test;

    typedef struct {
        logic [31:0] id;
        logic [31:0] cx;
        logic [31:0] cy;
        logic [30:0] hw;
        logic [30:0] hh;
        logic [15:0] ang;
        logic        gend;
    } t_rect;

    localparam int STEPS = 16;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [rrch_pkg::PADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    rrch_rect_if rect_ch ();
    rrch_hit_if hit_ch ();

    rotated_rect_circle_hit #(.CORDIC_STEPS(STEPS)) i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .psel(psel), .penable(penable),
        .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
        .pready(pready), .i_rect(rect_ch.sink), .o_hit(hit_ch.source)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // predictor state: circle registers and running group maximum
    logic signed [31:0] circ_x, circ_y;
    logic [30:0] circ_r;
    logic [31:0] group_best;

    t_rect pending_rects[$];
    logic [31:0] expected_hits[$];
    int errors = 0;
    bit calm = 0;          // no idling in the last part
    int hold_off = 0;      // long receiver stall, in cycles
    bit send_pause = 0;
    bit rect_taken = 0;    // rectangle word accepted at the last rising edge

    function automatic logic [31:0] atan_entry(int i);
        logic [31:0] t[24] = '{32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC,
            32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55,
            32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF,
            32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
            32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF,
            32'h0000007F};
        return t[i];
    endfunction

    // does the rectangle touch the circle; updates nothing
    function automatic bit rect_touches(t_rect r);
        longint z, x, y, xs, ys, c, s, dx, dy, rx, ry, ex, ey, rad;
        longint unsigned mx, my;
        bit flip;
        z = longint'($signed(r.ang)) * 131072;
        x = 652032874; y = 0; flip = 0;
        if (z > 1686629713) begin
            z -= 64'sd3373259426; flip = 1;
        end else if (z < -1686629713) begin
            z += 64'sd3373259426; flip = 1;
        end
        for (int i = 0; i < STEPS; i++) begin
            xs = x >>> i; ys = y >>> i;
            if (z >= 0) begin
                x -= ys; y += xs; z -= longint'(atan_entry(i));
            end else begin
                x += ys; y -= xs; z += longint'(atan_entry(i));
            end
        end
        if (flip) begin
            x = -x; y = -y;
        end
        c = x >>> 6; s = y >>> 6;
        dx = longint'(circ_x) - longint'($signed(r.cx));
        dy = longint'(circ_y) - longint'($signed(r.cy));
        rx = dx * c - dy * s;
        ry = dx * s + dy * c;
        mx = (rx < 0) ? -rx : rx;
        my = (ry < 0) ? -ry : ry;
        rad = longint'(circ_r);
        ex = longint'(mx >> 24) - longint'(r.hw);
        ey = longint'(my >> 24) - longint'(r.hh);
        if (ex > rad || ey > rad) return 0;
        if (ex <= 0 || ey <= 0) return 1;
        return (ex * ex + ey * ey) <= rad * rad;
    endfunction

    // acceptance is seen at the rising edge
    always @(posedge i_clk) begin
        rect_taken <= i_rst_n && rect_ch.valid && rect_ch.ready;
    end

    // driver: rectangle words from the queue, random gaps
    int src_gap = 0;
    always @(negedge i_clk) begin
        if (rect_taken) begin
            if (rect_touches(pending_rects[0]) && pending_rects[0].id > group_best)
                group_best = pending_rects[0].id;
            if (pending_rects[0].gend) begin
                expected_hits.push_back(group_best);
                group_best = 0;
            end
            void'(pending_rects.pop_front());
        end
        if (rect_taken || !rect_ch.valid) begin
            if (src_gap > 0) src_gap--;
            else if (!calm && $urandom_range(0, 9) == 0) src_gap = $urandom_range(1, 6);
            if (src_gap == 0 && !send_pause && pending_rects.size() > 0 && i_rst_n) begin
                rect_ch.valid <= 1'b1;
                rect_ch.rect_id <= pending_rects[0].id;
                rect_ch.rect_cx <= pending_rects[0].cx;
                rect_ch.rect_cy <= pending_rects[0].cy;
                rect_ch.half_w <= pending_rects[0].hw;
                rect_ch.half_h <= pending_rects[0].hh;
                rect_ch.rot_angle <= pending_rects[0].ang;
                rect_ch.group_end <= pending_rects[0].gend;
            end else
                rect_ch.valid <= 1'b0;
        end
    end

    // receiver stalls
    int snk_gap = 0;
    always @(negedge i_clk) begin
        if (hold_off > 0) begin
            hold_off--;
            hit_ch.ready <= 1'b0;
        end else begin
            if (snk_gap > 0) snk_gap--;
            else if (!calm && $urandom_range(0, 7) == 0) snk_gap = $urandom_range(1, 6);
            hit_ch.ready <= (snk_gap == 0);
        end
    end

    // monitor: compare result words with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && hit_ch.valid && hit_ch.ready) begin
            if (expected_hits.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected hit word %h", hit_ch.hit_id);
            end else begin
                if (hit_ch.hit_id !== expected_hits[0]) begin
                    errors++;
                    if (errors <= 10)
                        $display("hit_id mismatch: expected %h got %h",
                                 expected_hits[0], hit_ch.hit_id);
                end
                void'(expected_hits.pop_front());
            end
        end
    end

    task automatic apb_write(logic [1:0] idx, logic [31:0] val);
        @(negedge i_clk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= {idx, 2'b00}; pwdata <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            rrch_pkg::REG_CIRCLE_X: circ_x = val;
            rrch_pkg::REG_CIRCLE_Y: circ_y = val;
            rrch_pkg::REG_CIRCLE_R: circ_r = val[30:0];
            default: ;
        endcase
    endtask

    task automatic set_circle(logic [31:0] x, logic [31:0] y, logic [31:0] r);
        apb_write(rrch_pkg::REG_CIRCLE_X, x);
        apb_write(rrch_pkg::REG_CIRCLE_Y, y);
        apb_write(rrch_pkg::REG_CIRCLE_R, r);
    endtask

    // wait until every word is sent and answered, then past the block latency
    task automatic drain();
        while (pending_rects.size() > 0 || rect_ch.valid || expected_hits.size() > 0)
            @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    // random rectangle near the circle so hits and misses both occur
    function automatic t_rect near_rect(bit gend);
        t_rect r;
        int span;
        span = 1 << $urandom_range(10, 24);
        r.id = ($urandom_range(0, 7) == 0) ? 32'd0 :
               ($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(1, 200));
        r.cx = circ_x + $signed($urandom_range(0, 2 * span)) - span;
        r.cy = circ_y + $signed($urandom_range(0, 2 * span)) - span;
        r.hw = 31'($urandom_range(0, span));
        r.hh = 31'($urandom_range(0, span));
        r.ang = 16'($urandom);
        r.gend = gend;
        return r;
    endfunction

    function automatic t_rect wild_rect();
        t_rect r;
        r.id = $urandom; r.cx = $urandom; r.cy = $urandom;
        r.hw = 31'($urandom); r.hh = 31'($urandom); r.ang = 16'($urandom);
        r.gend = 1'($urandom_range(0, 1));
        return r;
    endfunction

    function automatic void push_group(int n);
        for (int i = 0; i < n; i++)
            pending_rects.push_back(near_rect(i == n - 1));
    endfunction

    initial begin
        t_rect r;
        rect_ch.valid = 1'b0; rect_ch.rect_id = '0; rect_ch.rect_cx = '0;
        rect_ch.rect_cy = '0; rect_ch.half_w = '0; rect_ch.half_h = '0;
        rect_ch.rot_angle = '0; rect_ch.group_end = 1'b0;
        hit_ch.ready = 1'b0;
        circ_x = 0; circ_y = 0; circ_r = 0; group_best = 0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: unit circle at origin
        set_circle(32'd0, 32'd0, 32'd65536);
        r = '{32'd5, 0, 0, 31'd65536, 31'd65536, 16'h0000, 1'b0};
        pending_rects.push_back(r);                     // inside
        r = '{32'd0, 0, 0, 31'd65536, 31'd65536, 16'h0000, 1'b1};
        pending_rects.push_back(r);                     // inactive slot hits
        r = '{32'hFFFFFFFF, 32'h00030000, 0, 31'd0, 31'd0, 16'h7FFF, 1'b1};
        pending_rects.push_back(r);                     // miss: group with no hit
        r = '{32'hFFFFFFFF, 32'h00018000, 32'h00018000, 31'h8000, 31'h8000,
              16'h8000, 1'b0};
        pending_rects.push_back(r);                     // corner region
        r = '{32'd7, 32'h80000000, 32'h7FFFFFFF, 31'h7FFFFFFF, 31'h7FFFFFFF,
              16'h3244, 1'b0};
        pending_rects.push_back(r);                     // field extremes
        r = '{32'd9, 32'h7FFFFFFF, 32'h80000000, 31'd0, 31'h7FFFFFFF,
              16'hCDBC, 1'b1};
        pending_rects.push_back(r);
        for (int i = 0; i < 6; i++) begin
            r = '{32'd1 << i, 32'h00010000 * i, 0, 31'h8000, 31'h4000,
                  16'(i * 11000), 1'(i % 2)};
            pending_rects.push_back(r);
        end
        drain();

        // extreme circle settings
        set_circle(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF);
        r = '{32'd3, 32'h80000000, 32'h7FFFFFFF, 31'd0, 31'd0, 16'h8000, 1'b1};
        pending_rects.push_back(r);
        for (int i = 0; i < 8; i++) pending_rects.push_back(wild_rect());
        pending_rects.push_back(near_rect(1));
        drain();

        set_circle(32'h80000000, 32'h7FFFFFFF, 32'd0);
        for (int i = 0; i < 4; i++) pending_rects.push_back(wild_rect());
        pending_rects.push_back(near_rect(1));
        drain();

        // random phases with varied circles
        for (int ph = 0; ph < 5; ph++) begin
            set_circle($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 1 << 22),
                       $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 1 << 22),
                       $urandom_range(0, 1 << $urandom_range(8, 30)));
            if (ph == 4) calm = 1;
            for (int k = 0; k < 64; k++) begin
                if ($urandom_range(0, 9) == 0) pending_rects.push_back(wild_rect());
                else push_group($urandom_range(1, 6));
            end
            pending_rects.push_back(near_rect(1));
            if (ph == 1) begin
                // long receiver stall while words keep coming
                hold_off = 400;
            end
            if (ph == 2) begin
                // sender waits for every result before continuing
                while (pending_rects.size() > 60) @(posedge i_clk);
                @(negedge i_clk);
                send_pause = 1;
                while (rect_ch.valid || expected_hits.size() > 0) @(posedge i_clk);
                @(negedge i_clk);
                send_pause = 0;
            end
            drain();
        end

        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial begin
        #2000000;
        $display("DONE: errors detected");
        $finish;
    end
endmodule
